[sv/i2c_pot_write_master_macros.svh]
`ifndef I2C_POT_WRITE_MASTER_MACROS_SVH
`define I2C_POT_WRITE_MASTER_MACROS_SVH

// Immediate implication on the same edge, expects clk and rst_n in scope
`define IPW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication on the following edge
`define IPW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/ipw_pkg.sv]
package ipw_pkg;

  localparam int CHANNELS_DEF = 2;
  localparam int CNT_W        = 16;
  localparam int ADDR_W       = 8;
  localparam int TV_W         = 16;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CNT_W-1:0]  START_TIME_RST = 16'd4700;
  localparam logic [CNT_W-1:0]  HIGH_TIME_RST  = 16'd4000;
  localparam logic [CNT_W-1:0]  LOW_TIME_RST   = 16'd3000;
  localparam logic [CNT_W-1:0]  SETUP_TIME_RST = 16'd1700;
  localparam logic [ADDR_W-1:0] DEV_ADDR_RST   = 8'h5E;
  localparam logic [7:0]        DATA_MAX       = 8'h7F;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_TIME = 3'd0,
    CFG_HIGH_TIME  = 3'd1,
    CFG_LOW_TIME   = 3'd2,
    CFG_SETUP_TIME = 3'd3,
    CFG_DEV_ADDR   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_ST_C,
    PH_B_SU,
    PH_B_HI,
    PH_B_LO,
    PH_A_SU,
    PH_A_HI,
    PH_A_LO,
    PH_N_WAIT,
    PH_C_SU,
    PH_C_HI,
    PH_C_STOP
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0]  start_time;
    logic [CNT_W-1:0]  high_time;
    logic [CNT_W-1:0]  low_time;
    logic [CNT_W-1:0]  setup_time;
    logic [ADDR_W-1:0] dev_addr;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic            channel;
    logic [TV_W-1:0] target_value;
    logic            sda_in;
  } in_item_t;

  function automatic logic [7:0] clamp127(logic [TV_W-1:0] v);
    logic [7:0] r;
    r = (v > TV_W'(DATA_MAX)) ? DATA_MAX : v[7:0];
    return r;
  endfunction

endpackage

[sv/ipw_if.sv]
interface ipw_in_if;
  import ipw_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic            channel;
  logic [TV_W-1:0] target_value;
  logic            sda_in;

  modport source (output valid, kind, channel, target_value, sda_in, input ready);
  modport sink   (input valid, kind, channel, target_value, sda_in, output ready);
endinterface

interface ipw_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_level;
  logic sda_drive;
  logic active_channel;
  logic busy_res;
  logic nack_event;
  logic done_event;

  modport source (output valid, scl, sda_level, sda_drive, active_channel, busy_res,
                  nack_event, done_event, input ready);
  modport sink   (input valid, scl, sda_level, sda_drive, active_channel, busy_res,
                  nack_event, done_event, output ready);
endinterface

interface ipw_cfg_if;
  import ipw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CNT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/ipw_cfg_regs.sv]
module ipw_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  ipw_cfg_if.sink       cfg_if,
  output ipw_pkg::cfg_t cfg
);
  import ipw_pkg::*;

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg          = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_time <= START_TIME_RST;
      cfg_r.high_time  <= HIGH_TIME_RST;
      cfg_r.low_time   <= LOW_TIME_RST;
      cfg_r.setup_time <= SETUP_TIME_RST;
      cfg_r.dev_addr   <= DEV_ADDR_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        CFG_START_TIME: cfg_r.start_time <= cfg_if.data;
        CFG_HIGH_TIME:  cfg_r.high_time  <= cfg_if.data;
        CFG_LOW_TIME:   cfg_r.low_time   <= cfg_if.data;
        CFG_SETUP_TIME: cfg_r.setup_time <= cfg_if.data;
        CFG_DEV_ADDR:   cfg_r.dev_addr   <= cfg_if.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/ipw_in_stage.sv]
module ipw_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  ipw_in_if.sink            in_if,
  input  logic              take,
  output logic              item_valid,
  output ipw_pkg::in_item_t item
);
  import ipw_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_if.ready = !valid_r || take;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.kind         <= in_if.kind;
      item_r.channel      <= in_if.channel;
      item_r.target_value <= in_if.target_value;
      item_r.sda_in       <= in_if.sda_in;
    end
  end

endmodule

[sv/ipw_core.sv]
module ipw_core #(
  parameter int CHANNELS = ipw_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ipw_pkg::cfg_t     cfg,
  input  logic              item_valid,
  input  ipw_pkg::in_item_t item,
  output logic              take,
  ipw_out_if.source         out_if
);
  import ipw_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  phase_t                 phase_r, phase_nxt;
  logic [CNT_W-1:0]       tick_r, tick_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic                   bsel_r, bsel_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             data_r, data_nxt;
  logic [CH_W-1:0]        cur_r, cur_nxt;
  logic [TV_W-1:0]        target_r [CHANNELS];
  logic [TV_W-1:0]        target_nxt [CHANNELS];
  logic [TV_W-1:0]        last_r [CHANNELS];
  logic [TV_W-1:0]        last_nxt [CHANNELS];
  logic [CHANNELS-1:0]    init_r, init_nxt;

  logic                   fire;
  logic [CNT_W-1:0]       len;
  logic [CNT_W:0]         tick_inc;
  logic                   nack, done;
  logic                   scl, lvl, drv;

  logic                   out_valid_r;
  logic                   scl_r, lvl_r, drv_r, chan_r, busy_r, nack_r, done_r;

  assign fire = item_valid && (!out_valid_r || out_if.ready);
  assign take = fire;

  always_comb begin
    case (phase_r)
      PH_ST_A:                                        len = cfg.start_time;
      PH_ST_B, PH_B_HI, PH_A_HI, PH_C_HI, PH_C_STOP: len = cfg.high_time;
      PH_ST_C, PH_B_LO, PH_A_LO:                      len = cfg.low_time;
      default:                                        len = cfg.setup_time;
    endcase
  end

  assign tick_inc = {1'b0, tick_r} + 1'b1;

  always_comb begin
    logic found;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    bsel_nxt   = bsel_r;
    shift_nxt  = shift_r;
    data_nxt   = data_r;
    cur_nxt    = cur_r;
    target_nxt = target_r;
    last_nxt   = last_r;
    init_nxt   = init_r;
    nack       = 1'b0;
    done       = 1'b0;
    found      = 1'b0;

    if (item.kind) begin
      if (32'(item.channel) < CHANNELS) begin
        target_nxt[CH_W'(item.channel)] = item.target_value;
      end
    end else if (phase_r == PH_IDLE) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (!found && init_r[i]) begin
          found       = 1'b1;
          init_nxt[i] = 1'b0;
          cur_nxt     = CH_W'(i);
          data_nxt    = clamp127(last_r[i]);
        end
      end
      for (int i = 0; i < CHANNELS; i++) begin
        if (!found && (target_r[i] != last_r[i])) begin
          found       = 1'b1;
          last_nxt[i] = target_r[i];
          cur_nxt     = CH_W'(i);
          data_nxt    = clamp127(target_r[i]);
        end
      end
      if (found) begin
        bsel_nxt  = 1'b0;
        shift_nxt = cfg.dev_addr;
        bit_nxt   = '0;
        phase_nxt = PH_ST_A;
        tick_nxt  = '0;
      end
    end else if (phase_r == PH_A_HI && item.sda_in) begin
      nack      = 1'b1;
      phase_nxt = PH_N_WAIT;
      tick_nxt  = '0;
    end else begin
      tick_nxt = tick_inc[CNT_W-1:0];
      if (tick_inc >= {1'b0, len}) begin
        tick_nxt = '0;
        case (phase_r)
          PH_ST_A: phase_nxt = PH_ST_B;
          PH_ST_B: phase_nxt = PH_ST_C;
          PH_ST_C: begin
            bit_nxt   = '0;
            phase_nxt = PH_B_SU;
          end
          PH_B_SU: phase_nxt = PH_B_HI;
          PH_B_HI: phase_nxt = PH_B_LO;
          PH_B_LO: begin
            if (bit_r == 3'd7) begin
              phase_nxt = PH_A_SU;
            end else begin
              bit_nxt   = bit_r + 3'd1;
              phase_nxt = PH_B_SU;
            end
          end
          PH_A_SU: phase_nxt = PH_A_HI;
          PH_A_HI: phase_nxt = PH_A_LO;
          PH_A_LO: begin
            if (!bsel_r) begin
              bsel_nxt  = 1'b1;
              shift_nxt = data_r;
              bit_nxt   = '0;
              phase_nxt = PH_B_SU;
            end else begin
              phase_nxt = PH_C_SU;
            end
          end
          PH_N_WAIT: phase_nxt = PH_ST_A;
          PH_C_SU:   phase_nxt = PH_C_HI;
          PH_C_HI:   phase_nxt = PH_C_STOP;
          PH_C_STOP: begin
            done      = 1'b1;
            phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    scl = 1'b0;
    lvl = 1'b0;
    drv = 1'b1;
    case (phase_nxt)
      PH_IDLE:   lvl = 1'b1;
      PH_ST_A: begin
        scl = 1'b1;
        lvl = 1'b1;
      end
      PH_ST_B:   scl = 1'b1;
      PH_ST_C:   ;
      PH_B_SU, PH_B_LO: lvl = shift_nxt[3'd7 - bit_nxt];
      PH_B_HI: begin
        scl = 1'b1;
        lvl = shift_nxt[3'd7 - bit_nxt];
      end
      PH_A_HI: begin
        scl = 1'b1;
        drv = 1'b0;
      end
      PH_A_SU, PH_A_LO, PH_N_WAIT: drv = 1'b0;
      PH_C_SU:   ;
      PH_C_HI:   scl = 1'b1;
      PH_C_STOP: begin
        scl = 1'b1;
        lvl = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      bit_r   <= '0;
      bsel_r  <= 1'b0;
      shift_r <= '0;
      data_r  <= '0;
      cur_r   <= '0;
      init_r  <= '1;
      for (int i = 0; i < CHANNELS; i++) begin
        target_r[i] <= '0;
        last_r[i]   <= '0;
      end
    end else if (fire) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      bsel_r   <= bsel_nxt;
      shift_r  <= shift_nxt;
      data_r   <= data_nxt;
      cur_r    <= cur_nxt;
      init_r   <= init_nxt;
      target_r <= target_nxt;
      last_r   <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_r  <= scl;
      lvl_r  <= lvl;
      drv_r  <= drv;
      chan_r <= cur_nxt[0];
      busy_r <= (phase_nxt != PH_IDLE);
      nack_r <= nack;
      done_r <= done;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.scl            = scl_r;
  assign out_if.sda_level      = lvl_r;
  assign out_if.sda_drive      = drv_r;
  assign out_if.active_channel = chan_r;
  assign out_if.busy_res       = busy_r;
  assign out_if.nack_event     = nack_r;
  assign out_if.done_event     = done_r;

endmodule

[sv/i2c_pot_write_master.sv]
// Each accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while the result side keeps up; a result not yet taken stalls the core.
// Reset (rst_n low, synchronous): timing registers take their defaults, the bus state goes
// idle (SDA high, SCL low, though the output line registers keep their values), all targets
// clear, and every channel is queued for a zero write on the first idle ticks after reset.
`include "i2c_pot_write_master_macros.svh"

module i2c_pot_write_master #(
  parameter int CHANNELS = ipw_pkg::CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ipw_in_if.sink     in_if,
  ipw_out_if.source  out_if,
  ipw_cfg_if.sink    cfg_if
);
  import ipw_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  logic     item_valid;
  logic     take;

  ipw_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  ipw_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  ipw_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_if     (out_if)
  );

  `IPW_ASSERT_NOW(a_nack_releases, out_if.valid && out_if.nack_event, !out_if.sda_drive, "nack without SDA release")
  `IPW_ASSERT_NOW(a_done_idle, out_if.valid && out_if.done_event, !out_if.busy_res, "stop done but still busy")
  `IPW_ASSERT_NOW(a_nack_busy, out_if.valid && out_if.nack_event, out_if.busy_res && out_if.scl == 1'b0, "nack outside a transfer")
  `IPW_ASSERT_NEXT(a_take_valid, take, out_if.valid, "item taken without a result")

endmodule

[sim/ipw_bus_tracker.sv]
module ipw_bus_tracker
  import ipw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ipw_in_if    in_w,
  ipw_out_if   out_w,
  ipw_cfg_if   cfg_w,
  output int   fail_count,
  output int   pending,
  output int   item_count,
  output int   nack_count,
  output int   done_count,
  output int   cfg_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = CHANNELS_DEF;

  typedef struct packed {
    logic scl;
    logic sda_level;
    logic sda_drive;
    logic active_channel;
    logic busy_res;
    logic nack_event;
    logic done_event;
  } lines_t;

  cfg_t            regs;
  phase_t          ph;
  int              ticks;
  logic [3:0]      bit_idx;
  logic            byte_sel;
  logic [7:0]      shifter;
  logic            chan;
  logic [TV_W-1:0] target [NCH];
  logic [TV_W-1:0] sent [NCH];
  logic [NCH-1:0]  init_left;
  lines_t          lines_q [$];
  int              fails;
  int              items;
  int              nacks;
  int              dones;
  int              writes;

  function automatic void clear_bus();
    regs.start_time = START_TIME_RST;
    regs.high_time  = HIGH_TIME_RST;
    regs.low_time   = LOW_TIME_RST;
    regs.setup_time = SETUP_TIME_RST;
    regs.dev_addr   = DEV_ADDR_RST;
    ph = PH_IDLE;
    ticks = 0;
    bit_idx = '0;
    byte_sel = 1'b0;
    shifter = '0;
    chan = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      target[c] = '0;
      sent[c] = '0;
    end
    init_left = '1;
  endfunction

  function automatic int phase_len(phase_t p);
    case (p)
      PH_ST_A: return int'(regs.start_time);
      PH_ST_B, PH_B_HI, PH_A_HI, PH_C_HI, PH_C_STOP: return int'(regs.high_time);
      PH_ST_C, PH_B_LO, PH_A_LO: return int'(regs.low_time);
      default: return int'(regs.setup_time);
    endcase
  endfunction

  function automatic void enter(phase_t p);
    ph = p;
    ticks = 0;
  endfunction

  function automatic void open_transfer();
    int pick;
    pick = -1;
    for (int c = 0; c < NCH; c++)
      if (pick < 0 && init_left[c]) pick = c;
    if (pick >= 0) begin
      init_left[pick] = 1'b0;
    end else begin
      for (int c = 0; c < NCH; c++)
        if (pick < 0 && target[c] != sent[c]) pick = c;
      if (pick >= 0) sent[pick] = target[pick];
    end
    if (pick >= 0) begin
      chan = 1'(pick);
      byte_sel = 1'b0;
      shifter = regs.dev_addr;
      bit_idx = '0;
      enter(PH_ST_A);
    end
  endfunction

  function automatic lines_t lines_after(in_item_t it);
    lines_t r;
    logic   bit_now;
    r = '0;
    if (it.kind) begin
      if (int'(it.channel) < NCH) target[it.channel] = it.target_value;
    end else if (ph == PH_IDLE) begin
      open_transfer();
    end else if (ph == PH_A_HI && it.sda_in) begin
      r.nack_event = 1'b1;
      enter(PH_N_WAIT);
    end else begin
      ticks++;
      if (ticks >= phase_len(ph)) begin
        case (ph)
          PH_ST_A: enter(PH_ST_B);
          PH_ST_B: enter(PH_ST_C);
          PH_ST_C: begin
            bit_idx = '0;
            enter(PH_B_SU);
          end
          PH_B_SU: enter(PH_B_HI);
          PH_B_HI: enter(PH_B_LO);
          PH_B_LO: begin
            if (bit_idx >= 4'd7) begin
              enter(PH_A_SU);
            end else begin
              bit_idx++;
              enter(PH_B_SU);
            end
          end
          PH_A_SU: enter(PH_A_HI);
          PH_A_HI: enter(PH_A_LO);
          PH_A_LO: begin
            if (!byte_sel) begin
              byte_sel = 1'b1;
              shifter = (sent[chan] > TV_W'(DATA_MAX)) ? DATA_MAX : sent[chan][7:0];
              bit_idx = '0;
              enter(PH_B_SU);
            end else begin
              enter(PH_C_SU);
            end
          end
          PH_N_WAIT: enter(PH_ST_A);
          PH_C_SU: enter(PH_C_HI);
          PH_C_HI: enter(PH_C_STOP);
          PH_C_STOP: begin
            r.done_event = 1'b1;
            enter(PH_IDLE);
          end
          default: enter(PH_IDLE);
        endcase
      end
    end

    bit_now = shifter[3'd7 - bit_idx[2:0]];
    r.sda_drive = 1'b1;
    case (ph)
      PH_IDLE: begin
        r.scl = 1'b0;
        r.sda_level = 1'b1;
      end
      PH_ST_A: begin
        r.scl = 1'b1;
        r.sda_level = 1'b1;
      end
      PH_ST_B: r.scl = 1'b1;
      PH_B_SU, PH_B_LO: r.sda_level = bit_now;
      PH_B_HI: begin
        r.scl = 1'b1;
        r.sda_level = bit_now;
      end
      PH_A_HI: begin
        r.scl = 1'b1;
        r.sda_drive = 1'b0;
      end
      PH_A_SU, PH_A_LO, PH_N_WAIT: r.sda_drive = 1'b0;
      PH_C_HI: r.scl = 1'b1;
      PH_C_STOP: begin
        r.scl = 1'b1;
        r.sda_level = 1'b1;
      end
      default: ;
    endcase
    r.active_channel = chan;
    r.busy_res = (ph != PH_IDLE);
    return r;
  endfunction

  always @(posedge clk) begin
    in_item_t it;
    lines_t   got;
    lines_t   want;
    if (!rst_n) begin
      clear_bus();
      lines_q.delete();
      fails = 0;
      items = 0;
      nacks = 0;
      dones = 0;
      writes = 0;
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        writes++;
        case (cfg_idx_t'(cfg_w.index))
          CFG_START_TIME: regs.start_time = cfg_w.data;
          CFG_HIGH_TIME:  regs.high_time = cfg_w.data;
          CFG_LOW_TIME:   regs.low_time = cfg_w.data;
          CFG_SETUP_TIME: regs.setup_time = cfg_w.data;
          CFG_DEV_ADDR:   regs.dev_addr = cfg_w.data[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        it = {in_w.kind, in_w.channel, in_w.target_value, in_w.sda_in};
        lines_q.push_back(lines_after(it));
        items++;
      end
      if (out_w.valid && out_w.ready) begin
        got = {out_w.scl, out_w.sda_level, out_w.sda_drive, out_w.active_channel,
               out_w.busy_res, out_w.nack_event, out_w.done_event};
        if (lines_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result %7b with no item outstanding", $realtime, got);
        end else begin
          want = lines_q.pop_front();
          nacks += want.nack_event;
          dones += want.done_event;
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: lines (scl sda_level sda_drive chan busy nack done) exp %7b got %7b",
                       $realtime, want, got);
          end
        end
      end
    end
    fail_count <= fails;
    pending <= lines_q.size();
    item_count <= items;
    nack_count <= nacks;
    done_count <= dones;
    cfg_count <= writes;
  end

endmodule

[sim/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ipw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   item_count;
  int   nack_count;
  int   done_count;
  int   cfg_count;
  int   idle_cycles;
  bit   tx_idle;
  bit   rx_idle;
  int   rx_hold;
  int   sda_odds;
  int   set_pct;

  ipw_in_if  in_w ();
  ipw_out_if out_w ();
  ipw_cfg_if cfg_w ();

  i2c_pot_write_master dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_w),
    .out_if (out_w),
    .cfg_if (cfg_w)
  );

  ipw_bus_tracker tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_w       (in_w),
    .out_w      (out_w),
    .cfg_w      (cfg_w),
    .fail_count (fail_count),
    .pending    (pending),
    .item_count (item_count),
    .nack_count (nack_count),
    .done_count (done_count),
    .cfg_count  (cfg_count)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready) ||
        (cfg_w.valid && cfg_w.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_w.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = rx_idle ? $urandom_range(0, 7) : 0;
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_w.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_w.ready <= 1'b1;
      @(posedge clk iff (out_w.valid && out_w.ready));
    end
  end

  function automatic in_item_t tick_item(logic sda);
    in_item_t it;
    it = '0;
    it.sda_in = sda;
    return it;
  endfunction

  function automatic in_item_t target_item(logic ch, logic [TV_W-1:0] v);
    in_item_t it;
    it = '0;
    it.kind = 1'b1;
    it.channel = ch;
    it.target_value = v;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.kind = ($urandom_range(0, 99) < set_pct);
    it.channel = 1'($urandom);
    case ($urandom_range(0, 4))
      0: it.target_value = TV_W'($urandom_range(0, 127));
      1: it.target_value = TV_W'($urandom_range(120, 135));
      2: it.target_value = $urandom_range(0, 1) ? '1 : '0;
      default: it.target_value = TV_W'($urandom);
    endcase
    it.sda_in = ($urandom_range(1, sda_odds) == 1);
    return it;
  endfunction

  function automatic cfg_t random_regs(int hi);
    cfg_t c;
    c.start_time = CNT_W'($urandom_range(0, hi));
    c.high_time  = CNT_W'($urandom_range(0, hi));
    c.low_time   = CNT_W'($urandom_range(0, hi));
    c.setup_time = CNT_W'($urandom_range(0, hi));
    c.dev_addr   = ADDR_W'($urandom);
    return c;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_w.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_w.valid        <= 1'b1;
    in_w.kind         <= it.kind;
    in_w.channel      <= it.channel;
    in_w.target_value <= it.target_value;
    in_w.sda_in       <= it.sda_in;
    @(posedge clk iff in_w.ready);
  endtask

  task automatic drain();
    in_w.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(cfg_t c, bit spare);
    cfg_idx_t         order [5];
    logic [CNT_W-1:0] vals [5];
    order = '{CFG_START_TIME, CFG_HIGH_TIME, CFG_LOW_TIME, CFG_SETUP_TIME, CFG_DEV_ADDR};
    vals = '{c.start_time, c.high_time, c.low_time, c.setup_time,
             {8'($urandom), c.dev_addr}};
    for (int i = 0; i < 5; i++) begin
      cfg_w.valid <= 1'b1;
      cfg_w.index <= order[i];
      cfg_w.data  <= vals[i];
      @(posedge clk iff cfg_w.ready);
    end
    if (spare) begin
      cfg_w.valid <= 1'b1;
      cfg_w.index <= CFG_SPARE_IDX;
      cfg_w.data  <= CNT_W'($urandom);
      @(posedge clk iff cfg_w.ready);
    end
    cfg_w.valid <= 1'b0;
  endtask

  initial begin
    int   plan [6];
    cfg_t setting;
    plan = '{200, 200, 60, 230, 230, 230};
    rst_n             <= 1'b0;
    in_w.valid        <= 1'b0;
    in_w.kind         <= 1'b0;
    in_w.channel      <= 1'b0;
    in_w.target_value <= '0;
    in_w.sda_in       <= 1'b0;
    cfg_w.valid       <= 1'b0;
    cfg_w.index       <= CFG_START_TIME;
    cfg_w.data        <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 0;
    sda_odds = 16;
    set_pct = 10;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing: first tick opens the zero write of channel 0
    send_item(tick_item(1'b0));
    send_item(target_item(1'b1, '1));
    send_item(tick_item(1'b1));
    drain();

    setting = '{16'd1, 16'd1, 16'd1, 16'd0, 8'h00};
    program_regs(setting, 1'b1);
    send_item(target_item(1'b0, 16'd128));
    send_item(target_item(1'b1, 16'hFFFF));
    send_item(target_item(1'b1, 16'd127));
    repeat (14) send_item(tick_item(1'b0));
    repeat (2) send_item(tick_item(1'b1));
    repeat (4) send_item(tick_item(1'b0));

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          setting = '{16'd1, 16'd1, 16'd1, 16'd1, 8'hFF};
          program_regs(setting, 1'b0);
        end
        1: begin
          program_regs(random_regs(3), 1'b0);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ADDR_W'($urandom)};
          program_regs(setting, 1'b0);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        3: begin
          setting = '{16'd0, 16'd0, 16'd0, 16'd0, 8'h00};
          program_regs(setting, 1'b1);
        end
        4: begin
          program_regs(random_regs(4), 1'b0);
          sda_odds = 2;
          set_pct = 20;
          tx_idle = 1'b0;
          rx_hold = LONG_HOLD;
        end
        default: begin
          program_regs(random_regs(2), 1'b0);
          sda_odds = 16;
          set_pct = 10;
          tx_idle = 1'b1;
        end
      endcase
      for (int n = 0; n < plan[p]; n++) begin
        if (p == 5 && n == plan[p] / 2) drain();
        send_item(random_item());
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items over %0d register writes: %0d transfers closed, %0d nacks",
             item_count, cfg_count, done_count, nack_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
